[src/srfo_pkg.sv]
// Shared types and constants for the section address translator.
// No dependencies; used by every module under src.
package srfo_pkg;

  localparam int MAX_SECTIONS = 96;
  localparam int HEADER_BYTES = 40;

  localparam int ADDR_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_SECTIONS + 1);
  localparam int END_W  = 33;
  localparam int SLOT_W = 7;

  localparam logic [1:0] REG_SECTION_COUNT  = 2'd0;
  localparam logic [1:0] REG_TABLE_POSITION = 2'd1;
  localparam logic [1:0] REG_IMAGE_LENGTH   = 2'd2;

  localparam logic KIND_LOAD      = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] entry_slot;
    logic [31:0]       entry_virtual_base;
    logic [31:0]       entry_raw_base;
    logic [31:0]       query_address;
  } item_t;

  typedef struct packed {
    logic [32:0] file_position;
    logic        bounds_error;
  } result_t;

  typedef struct packed {
    logic [15:0] section_count;
    logic [31:0] table_position;
    logic [31:0] image_length;
  } cfg_t;

  typedef struct packed {
    logic [31:0] virt;
    logic [31:0] raw;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

[src/srfo_table.sv]
// Section entry store: one write port, one registered read port.
// Depends on srfo_pkg.
module srfo_table (
  input  logic             clk,
  input  srfo_pkg::wr_req_t wr,
  input  srfo_pkg::rd_req_t rd,
  output srfo_pkg::entry_t  rd_data
);

  logic [31:0] virt_mem [srfo_pkg::MAX_SECTIONS];
  logic [31:0] raw_mem  [srfo_pkg::MAX_SECTIONS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      virt_mem[wr.addr] <= wr.data.virt;
      raw_mem[wr.addr]  <= wr.data.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data.virt <= virt_mem[rd.addr];
      rd_data.raw  <= raw_mem[rd.addr];
    end
  end

endmodule

[src/srfo_scan.sv]
// Translation sequencer: walks the entry table one slot per cycle, keeps the
// best match, checks header bounds, and forms the result. Depends on srfo_pkg.
module srfo_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [31:0]         query,
  input  srfo_pkg::cfg_t      cfg,
  output srfo_pkg::rd_req_t   rd,
  input  srfo_pkg::entry_t    rd_data,
  output logic                busy,
  output logic                done,
  output srfo_pkg::result_t   result
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                      state;
  logic [srfo_pkg::CNT_W-1:0]  idx;
  logic [srfo_pkg::CNT_W-1:0]  limit;
  logic [srfo_pkg::END_W-1:0]  end_acc;
  logic [31:0]                 query_q;
  logic [31:0]                 base;
  logic [31:0]                 raw;
  logic                        err;
  logic                        rd_pend;
  logic                        issue;
  logic [srfo_pkg::CNT_W-1:0]  limit_next;
  logic [31:0]                 diff;

  always_comb begin
    if (cfg.section_count > 16'(srfo_pkg::MAX_SECTIONS)) begin
      limit_next = srfo_pkg::CNT_W'(srfo_pkg::MAX_SECTIONS);
    end else begin
      limit_next = cfg.section_count[srfo_pkg::CNT_W-1:0];
    end
  end

  assign issue   = (state == S_SCAN) && (idx != limit);
  assign rd.en   = issue;
  assign rd.addr = idx[srfo_pkg::ADDR_W-1:0];
  assign busy    = (state != S_IDLE);
  assign diff    = query_q - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= issue;
      case (state)
        S_IDLE: begin
          if (go) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issue && !rd_pend) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (go) begin
          query_q <= query;
          idx     <= '0;
          limit   <= limit_next;
          end_acc <= {1'b0, cfg.table_position}
                     + srfo_pkg::END_W'(srfo_pkg::HEADER_BYTES);
          base    <= '0;
          raw     <= '0;
          err     <= 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx     <= idx + 1'b1;
          end_acc <= end_acc + srfo_pkg::END_W'(srfo_pkg::HEADER_BYTES);
          if (end_acc >= {1'b0, cfg.image_length}) begin
            err <= 1'b1;
          end
        end
        if (rd_pend && (query_q >= rd_data.virt) && (base <= rd_data.virt)) begin
          base <= rd_data.virt;
          raw  <= rd_data.raw;
        end
      end
      S_FINISH: begin
        if (err) begin
          result.file_position <= '0;
          result.bounds_error  <= 1'b1;
        end else begin
          result.file_position <= {1'b0, raw} + {1'b0, diff};
          result.bounds_error  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("result strobe without finish step");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bounds_error) |-> (result.file_position == '0))
    else $error("bounds failure with nonzero position");

  a_pend_follows_issue: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(issue))
    else $error("read data pending without a read");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= limit))
    else $error("scan index past limit");

endmodule

[src/section_rva_to_file_offset.sv]
// Top level of the section address translator: config registers, entry
// table and scan sequencer. Depends on srfo_pkg, srfo_table, srfo_scan.
//
// Usage:
//   Items enter on item when start is high and busy is low. A load item
//   (kind 0) writes entry_slot of the table in that cycle, leaves busy low
//   and gives no result; slots not below the table depth are ignored.
//   A translate item (kind 1) raises busy while the table is walked one
//   entry per cycle through the table's single read port. Its result shows
//   on result for exactly one cycle with done high once the first N slots
//   are walked, N being the smaller of section_count and the table depth;
//   busy drops in the cycle done rises, so the next item may transfer then.
//   The receiver cannot stall: a result is taken in the cycle it is shown.
//   Config writes use cfg_valid/cfg_ready (always ready) with cfg_index
//   0 section_count, 1 table_position, 2 image_length; other indexes are
//   dropped. Write config only while idle.
//   Reset (rst, synchronous) clears the sequencer and the registers; table
//   contents are undefined until loaded, so translate only after every
//   scanned slot has been written.
module section_rva_to_file_offset (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  srfo_pkg::item_t   item,
  output logic              done,
  output srfo_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  srfo_pkg::cfg_t    cfg;
  srfo_pkg::wr_req_t wr;
  srfo_pkg::rd_req_t rd;
  srfo_pkg::entry_t  rd_data;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srfo_pkg::REG_SECTION_COUNT:  cfg.section_count  <= cfg_data[15:0];
        srfo_pkg::REG_TABLE_POSITION: cfg.table_position <= cfg_data;
        srfo_pkg::REG_IMAGE_LENGTH:   cfg.image_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wr.en = accept && (item.kind == srfo_pkg::KIND_LOAD)
                 && ({1'b0, item.entry_slot} < 8'(srfo_pkg::MAX_SECTIONS));
  assign wr.addr      = item.entry_slot[srfo_pkg::ADDR_W-1:0];
  assign wr.data.virt = item.entry_virtual_base;
  assign wr.data.raw  = item.entry_raw_base;

  srfo_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  srfo_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .go      (accept && (item.kind == srfo_pkg::KIND_TRANSLATE)),
    .query   (item.query_address),
    .cfg     (cfg),
    .rd      (rd),
    .rd_data (rd_data),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

endmodule
